### hw/rtl/klfl_pkg.sv
// ============================================================================
// klfl_pkg
// Shared types and constants for the keyed LIFO free list.
// ============================================================================
package klfl_pkg;

  // Field widths fixed by the stream format
  localparam int IN_HANDLE_W = 16;
  localparam int IN_KEY_W    = 32;
  localparam int OUT_COUNT_W = 7;

  // Request kinds
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_GET  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } klfl_state_t;

  typedef struct packed {
    logic                   action;
    logic [IN_HANDLE_W-1:0] node_handle;
    logic [IN_KEY_W-1:0]    key_value;
  } klfl_req_t;

  typedef struct packed {
    logic                   found;
    logic [IN_HANDLE_W-1:0] found_handle;
    logic                   overflow;
    logic [OUT_COUNT_W-1:0] count_now;
  } klfl_result_t;

endpackage

### hw/rtl/klfl_engine.sv
// ============================================================================
// klfl_engine
// Handle and key stores with the push / search / close-gap sequencer.
// ============================================================================
module klfl_engine #(
  parameter int CAPACITY    = 64,
  parameter int KEY_BITS    = 32,
  parameter int HANDLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  klfl_pkg::klfl_req_t   req,
  output logic                  res_valid,
  input  logic                  res_ready,
  output klfl_pkg::klfl_result_t res
);
  import klfl_pkg::*;

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int HB_IN = (HANDLE_BITS < IN_HANDLE_W) ? HANDLE_BITS : IN_HANDLE_W;
  localparam int KB_IN = (KEY_BITS < IN_KEY_W) ? KEY_BITS : IN_KEY_W;

  // Stores: one write port, one registered read port each
  logic [HANDLE_BITS-1:0] handle_store [CAPACITY];
  logic [KEY_BITS-1:0]    key_store    [CAPACITY];

  klfl_state_t state, state_next;

  logic [CW-1:0]          count;
  logic [KEY_BITS-1:0]    key_q;
  logic [AW-1:0]          rd_idx;
  logic                   issuing;
  logic                   chk_valid;
  logic [AW-1:0]          chk_idx;
  logic [CW-1:0]          src;
  logic                   mv_valid;
  logic [AW-1:0]          mv_dst;
  klfl_result_t           res_q;

  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic [KEY_BITS-1:0]    rd_key;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [HANDLE_BITS-1:0] wr_handle;
  logic [KEY_BITS-1:0]    wr_key;

  logic [HANDLE_BITS-1:0] handle_in;
  logic [KEY_BITS-1:0]    key_in;
  logic                   full;
  logic                   empty;
  logic                   match;
  logic                   last_chk;
  logic                   src_active;
  logic                   shift_done;

  assign handle_in  = HANDLE_BITS'(req.node_handle[HB_IN-1:0]);
  assign key_in     = KEY_BITS'(req.key_value[KB_IN-1:0]);
  assign full       = (count == CW'(CAPACITY));
  assign empty      = (count == '0);
  assign match      = chk_valid && (rd_key == key_q);
  assign last_chk   = (chk_idx == '0);
  assign src_active = (src < count);
  assign shift_done = !src_active && !mv_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      handle_store[wr_addr] <= wr_handle;
      key_store[wr_addr]    <= wr_key;
    end
    if (rd_en) begin
      rd_handle <= handle_store[rd_addr];
      rd_key    <= key_store[rd_addr];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.action == ACT_GET && !empty) state_next = ST_SCAN;
          else                                 state_next = ST_RESP;
        end
      end
      ST_SCAN: begin
        if (match)                       state_next = ST_SHIFT;
        else if (chk_valid && last_chk)  state_next = ST_RESP;
      end
      ST_SHIFT: begin
        if (shift_done) state_next = ST_RESP;
      end
      ST_RESP: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = rd_idx;
    wr_en     = 1'b0;
    wr_addr   = count[AW-1:0];
    wr_handle = handle_in;
    wr_key    = key_in;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        wr_en     = req_valid && (req.action == ACT_PUSH) && !full;
      end
      ST_SCAN: begin
        rd_en   = issuing;
        rd_addr = rd_idx;
      end
      ST_SHIFT: begin
        rd_en     = src_active;
        rd_addr   = src[AW-1:0];
        wr_en     = mv_valid;
        wr_addr   = mv_dst;
        wr_handle = rd_handle;
        wr_key    = rd_key;
      end
      ST_RESP: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      issuing   <= 1'b0;
      chk_valid <= 1'b0;
      mv_valid  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            key_q              <= key_in;
            res_q.found        <= 1'b0;
            res_q.found_handle <= '0;
            res_q.overflow     <= 1'b0;
            res_q.count_now    <= OUT_COUNT_W'(count);
            chk_valid          <= 1'b0;
            issuing            <= 1'b0;
            if (req.action == ACT_PUSH) begin
              if (full) begin
                res_q.overflow <= 1'b1;
              end else begin
                count           <= count + 1'b1;
                res_q.count_now <= OUT_COUNT_W'(count + 1'b1);
              end
            end else begin
              issuing <= !empty;
              rd_idx  <= AW'(count - 1'b1);
            end
          end
        end
        ST_SCAN: begin
          // read one entry per cycle, newest first; compare each in the cycle after its read
          chk_valid <= issuing;
          chk_idx   <= rd_idx;
          if (issuing) begin
            if (rd_idx == '0) issuing <= 1'b0;
            else              rd_idx  <= rd_idx - 1'b1;
          end
          if (match) begin
            issuing            <= 1'b0;
            chk_valid          <= 1'b0;
            res_q.found        <= 1'b1;
            res_q.found_handle <= IN_HANDLE_W'(rd_handle[HB_IN-1:0]);
            src                <= CW'(chk_idx) + 1'b1;
            mv_valid           <= 1'b0;
          end
        end
        ST_SHIFT: begin
          // close the gap: read src, write it one slot down next cycle
          mv_valid <= src_active;
          mv_dst   <= AW'(src - 1'b1);
          if (src_active) src <= src + 1'b1;
          if (shift_done) begin
            count           <= count - 1'b1;
            res_q.count_now <= OUT_COUNT_W'(count - 1'b1);
          end
        end
        default: ;
      endcase
    end
  end

  assign res = res_q;

endmodule

### hw/rtl/keyed_lifo_free_list.sv
// ============================================================================
// keyed_lifo_free_list
// Bounded LIFO free list of node handles tagged with keys, searchable by key.
// ============================================================================
// A push stores a handle and its key as the newest entry, or is rejected with
// overflow set when CAPACITY entries are held. A get walks from the newest
// entry toward the oldest, removes the first entry whose key matches (the
// others keep their order) and returns its handle with found set; otherwise
// found and found_handle are zero. Every result carries the entry count after
// the request. One request is in the block at a time. Both stores sit in a
// single-port-read synchronous memory with one read per cycle. A get reads
// the entries from the newest down and compares each key with the request
// key; on a match it moves each newer entry one slot down, then returns its
// result, and a miss reads every entry before its result. A push writes its
// entry when it is accepted and then returns its result.
// A new request is taken while the previous result still waits on the master
// side. The stores need no clearing after reset: only slots below the count
// are ever read.
// ============================================================================
module keyed_lifo_free_list #(
  parameter int CAPACITY    = 64,
  parameter int KEY_BITS    = 32,
  parameter int HANDLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [15:0] node_handle, [47:16] key_value
  input  logic [0:0]  s_tuser,   // [0] action (0 push, 1 get)
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] found_handle, [22:16] count_now, [23] zero
  output logic [1:0]  m_tuser    // [0] found, [1] overflow
);
  import klfl_pkg::*;

  klfl_req_t    req;
  klfl_result_t res;
  logic         res_valid;
  logic         res_ready;

  assign req.action      = s_tuser[0];
  assign req.node_handle = s_tdata[15:0];
  assign req.key_value   = s_tdata[47:16];

  klfl_engine #(
    .CAPACITY    (CAPACITY),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: frees the engine as soon as a result is captured
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {1'b0, res.count_now, res.found_handle};
      m_tuser <= {res.overflow, res.found};
    end
  end

endmodule
